/* src/asfp_pkg.sv */
// Shared types, constants and digit helpers for the ASCII sensor frame parser.
// No dependencies; used by every module of the block.
package asfp_pkg;

	// Default number of ASCII length characters after the sync marker.
	localparam int unsigned LENGTH_DIGITS_DEF = 4;

	// Width of the length digit counter; it also counts the hunting window fill.
	localparam int unsigned DPOS_W = 3;

	// Sync word after reset: the characters "5120".
	localparam logic [31:0] SYNC_WORD_RESET = 32'd892416560;

	// Payload layout, as character indexes.
	localparam logic [13:0] IDX_NET_END  = 14'd2;
	localparam logic [13:0] IDX_ADDR_END = 14'd10;
	localparam logic [13:0] IDX_CODE     = 14'd10;
	localparam logic [13:0] IDX_READ_END = 14'd17;
	localparam logic [13:0] IDX_TS_END   = 14'd19;
	localparam logic [13:0] IDX_LQ_END   = 14'd21;

	// A payload shorter than this is flagged as a short frame.
	localparam logic [13:0] FULL_FRAME = 14'd21;

	// One sensor record as it leaves the block.
	typedef struct packed {
		logic [6:0]  network_id;
		logic [63:0] node_address;
		logic [7:0]  sensor_code;
		logic [47:0] sensor_reading;
		logic [6:0]  time_stamp;
		logic [6:0]  link_quality;
		logic [13:0] frame_length;
		logic        short_frame;
	} record_t;

	// True for the ASCII characters 0 through 9.
	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	// One decimal step on a 7-bit accumulator: acc * 10 + digit, wrapped.
	function automatic logic [6:0] dec7_step(input logic [6:0] acc, input logic [7:0] b);
		logic [6:0] digit;
		digit = 7'(b - 8'h30);
		return 7'({acc, 3'b000} + {acc, 1'b0} + digit);
	endfunction

	// One decimal step on a 14-bit accumulator: acc * 10 + digit, wrapped.
	function automatic logic [13:0] dec14_step(input logic [13:0] acc, input logic [7:0] b);
		logic [13:0] digit;
		digit = 14'(b - 8'h30);
		return 14'({acc, 3'b000} + {acc, 1'b0} + digit);
	endfunction

endpackage

/* src/asfp_frame_parse.sv */
// Frame parser: sync hunt, length decode and payload field capture.
// Depends on asfp_pkg for the record type, layout constants and digit helpers.
module asfp_frame_parse #(
	parameter int unsigned LENGTH_DIGITS = asfp_pkg::LENGTH_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         sync_word,
	input  logic [7:0]          byte_s1,
	input  logic                step,
	output logic                emit_req,
	output asfp_pkg::record_t   record
);

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_PAY  = 2'd2
	} phase_t;

	localparam logic [asfp_pkg::DPOS_W-1:0] LEN_LAST = asfp_pkg::DPOS_W'(LENGTH_DIGITS);
	localparam logic [asfp_pkg::DPOS_W-1:0] WIN_FULL = asfp_pkg::DPOS_W'(3);

	phase_t                        phase_q, phase_n;
	logic [23:0]                   recent_q, recent_n;
	logic [asfp_pkg::DPOS_W-1:0]   dpos_q, dpos_n;
	logic [13:0]                   len_q, len_n;
	logic                          len_stop_q, len_stop_n;
	logic [13:0]                   cnt_q, cnt_n;
	logic [2:0][6:0]               acc_q, acc_n;
	logic [2:0]                    stop_q, stop_n;
	logic [63:0]                   addr_q, addr_n;
	logic [7:0]                    code_q, code_n;
	logic [47:0]                   read_q, read_n;
	logic [31:0]                   window;
	logic [1:0]                    fsel;

	// Next-state logic for one received character.
	always_comb begin
		phase_n    = phase_q;
		recent_n   = recent_q;
		dpos_n     = dpos_q;
		len_n      = len_q;
		len_stop_n = len_stop_q;
		cnt_n      = cnt_q;
		acc_n      = acc_q;
		stop_n     = stop_q;
		addr_n     = addr_q;
		code_n     = code_q;
		read_n     = read_q;
		emit_req   = 1'b0;
		window     = {recent_q, byte_s1};
		fsel       = 2'd0;
		unique case (phase_q)
			PH_LEN: begin
				if (!len_stop_q && asfp_pkg::is_digit(byte_s1)) begin
					len_n = asfp_pkg::dec14_step(len_q, byte_s1);
				end else begin
					len_stop_n = 1'b1;
				end
				dpos_n = dpos_q + 1'b1;
				if (dpos_n >= LEN_LAST) begin
					if (len_n == 14'd0) begin
						emit_req = 1'b1;
						phase_n  = PH_HUNT;
						recent_n = '0;
						dpos_n   = '0;
					end else begin
						phase_n = PH_PAY;
						cnt_n   = '0;
					end
				end
			end
			PH_PAY: begin
				// Route the character to the field its index falls in.
				if (cnt_q < asfp_pkg::IDX_NET_END) begin
					fsel = 2'd1;
				end else if (cnt_q < asfp_pkg::IDX_ADDR_END) begin
					for (int i = 0; i < 8; i++) begin
						if (cnt_q == 14'(9 - i)) begin
							addr_n[8*i +: 8] = byte_s1;
						end
					end
				end else if (cnt_q == asfp_pkg::IDX_CODE) begin
					code_n = byte_s1;
				end else if (cnt_q < asfp_pkg::IDX_READ_END) begin
					for (int i = 0; i < 6; i++) begin
						if (cnt_q == 14'(16 - i)) begin
							read_n[8*i +: 8] = byte_s1;
						end
					end
				end else if (cnt_q < asfp_pkg::IDX_TS_END) begin
					fsel = 2'd2;
				end else if (cnt_q < asfp_pkg::IDX_LQ_END) begin
					fsel = 2'd3;
				end
				// Decimal fields stop converting at their first non-digit.
				for (int k = 0; k < 3; k++) begin
					if (fsel == 2'(k + 1) && !stop_q[k]) begin
						if (asfp_pkg::is_digit(byte_s1)) begin
							acc_n[k] = asfp_pkg::dec7_step(acc_q[k], byte_s1);
						end else begin
							stop_n[k] = 1'b1;
						end
					end
				end
				cnt_n = cnt_q + 14'd1;
				if (cnt_n >= len_q) begin
					emit_req = 1'b1;
					phase_n  = PH_HUNT;
					recent_n = '0;
					dpos_n   = '0;
				end
			end
			default: begin
				// Hunting, and the unused phase code behaves the same way.
				if (dpos_q >= WIN_FULL && window == sync_word) begin
					phase_n    = PH_LEN;
					dpos_n     = '0;
					recent_n   = '0;
					len_n      = '0;
					len_stop_n = 1'b0;
					cnt_n      = '0;
					acc_n      = '0;
					stop_n     = '0;
					addr_n     = '0;
					code_n     = '0;
					read_n     = '0;
				end else begin
					phase_n  = PH_HUNT;
					recent_n = window[23:0];
					if (dpos_q < WIN_FULL) begin
						dpos_n = dpos_q + 1'b1;
					end
				end
			end
		endcase
	end

	// The record is built from the values that include the current character.
	always_comb begin
		record.network_id     = acc_n[0];
		record.node_address   = addr_n;
		record.sensor_code    = code_n;
		record.sensor_reading = read_n;
		record.time_stamp     = acc_n[1];
		record.link_quality   = acc_n[2];
		record.frame_length   = len_n;
		record.short_frame    = (len_n < asfp_pkg::FULL_FRAME);
	end

	// Parser state registers, advanced once per processed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			recent_q   <= '0;
			dpos_q     <= '0;
			len_q      <= '0;
			len_stop_q <= 1'b0;
			cnt_q      <= '0;
			acc_q      <= '0;
			stop_q     <= '0;
			addr_q     <= '0;
			code_q     <= '0;
			read_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_n;
			recent_q   <= recent_n;
			dpos_q     <= dpos_n;
			len_q      <= len_n;
			len_stop_q <= len_stop_n;
			cnt_q      <= cnt_n;
			acc_q      <= acc_n;
			stop_q     <= stop_n;
			addr_q     <= addr_n;
			code_q     <= code_n;
			read_q     <= read_n;
		end
	end

endmodule

/* src/asfp_result_reg.sv */
// Result register holding one sensor record until the downstream side takes it.
// Depends on asfp_pkg for the record type.
module asfp_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  asfp_pkg::record_t record,
	output logic              free,
	output logic              out_valid,
	input  logic              out_ready,
	output asfp_pkg::record_t out_record
);

	logic              valid_q;
	asfp_pkg::record_t record_q;

	// A new record may enter when the register is empty or being drained.
	assign free       = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_record = record_q;

	// Valid flag of the held record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Record payload; no reset needed.
	always_ff @(posedge clk) begin
		if (load && free) begin
			record_q <= record;
		end
	end

endmodule

/* src/ascii_sensor_frame_parser.sv */
// ASCII sensor frame parser: one received character per cycle, one record per frame.
// The last character waits in the input register until its record can load the result register.
// Throughput: one character per cycle; input stalls only while a finished record waits
// and the next character would finish another.
// Reset: asynchronous, active low; hunting for sync with an empty window, sync word "5120".
module ascii_sensor_frame_parser #(
	parameter int unsigned LENGTH_DIGITS = asfp_pkg::LENGTH_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] sync_word,
	input  logic        rx_valid,
	output logic        rx_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  network_id,
	output logic [63:0] node_address,
	output logic [7:0]  sensor_code,
	output logic [47:0] sensor_reading,
	output logic [6:0]  time_stamp,
	output logic [6:0]  link_quality,
	output logic [13:0] frame_length,
	output logic        short_frame
);

	logic [31:0]       sync_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              emit_req;
	logic              advance;
	logic              free;
	asfp_pkg::record_t record;
	asfp_pkg::record_t out_record;

	// Sync word register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= asfp_pkg::SYNC_WORD_RESET;
		end else if (cfg_valid) begin
			sync_q <= sync_word;
		end
	end

	// The held character is processed unless its record has nowhere to go.
	assign advance  = valid_s1 && (!emit_req || free);
	assign rx_ready = !valid_s1 || advance;

	// Input register for one request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	asfp_frame_parse #(
		.LENGTH_DIGITS(LENGTH_DIGITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.sync_word(sync_q),
		.byte_s1  (byte_s1),
		.step     (advance),
		.emit_req (emit_req),
		.record   (record)
	);

	asfp_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit_req),
		.record    (record),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_record(out_record)
	);

	// Unpack the record onto the output ports.
	assign network_id     = out_record.network_id;
	assign node_address   = out_record.node_address;
	assign sensor_code    = out_record.sensor_code;
	assign sensor_reading = out_record.sensor_reading;
	assign time_stamp     = out_record.time_stamp;
	assign link_quality   = out_record.link_quality;
	assign frame_length   = out_record.frame_length;
	assign short_frame    = out_record.short_frame;

`ifndef ASSERT_OFF
	// The short frame flag agrees with the decoded length.
	a_short_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (short_frame == (frame_length < asfp_pkg::FULL_FRAME)))
		else $error("short_frame disagrees with frame_length");

	// Two-digit decimal fields never exceed 99.
	a_two_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (network_id <= 7'd99 && time_stamp <= 7'd99 && link_quality <= 7'd99))
		else $error("two-digit field out of range");

	// Input is refused only while a character is held and cannot advance.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rx_ready |-> (valid_s1 && emit_req && out_valid && !out_ready))
		else $error("input stalled without a blocked record");
`endif

endmodule

/* verif/tb_ascii_sensor_frame_parser.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII sensor frame parser: directed frames, then random streams.
// Depends on asfp_pkg (record type, reset sync word, length digit count) and the parser RTL.
module tb_ascii_sensor_frame_parser;

	localparam int DIGITS        = asfp_pkg::LENGTH_DIGITS_DEF;
	localparam int NET_END       = 2;
	localparam int ADDR_END      = 10;
	localparam int CODE_AT       = 10;
	localparam int READ_END      = 17;
	localparam int STAMP_END     = 19;
	localparam int LINK_END      = 21;
	localparam int FULL_LEN      = 21;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES    = 20;
	localparam int LONG_HOLD     = 400;
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_CHARS  = 1200;

	typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] sync_word = asfp_pkg::SYNC_WORD_RESET;
	logic        rx_valid = 1'b0;
	logic        rx_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [6:0]  network_id;
	logic [63:0] node_address;
	logic [7:0]  sensor_code;
	logic [47:0] sensor_reading;
	logic [6:0]  time_stamp;
	logic [6:0]  link_quality;
	logic [13:0] frame_length;
	logic        short_frame;

	// Characters waiting to be sent and records waiting to come out.
	logic [7:0]        stream_chars[$];
	asfp_pkg::record_t pending_records[$];
	int                queued_chars = 0;
	int                mismatches = 0;
	int                quiet_cycles = 0;

	// Idle control, set per part of the run.
	int rx_gap_pct = 0;
	int out_stall_pct = 0;
	int rx_gap_left = 0;
	int hold_left = 0;
	bit long_hold_go = 1'b0;
	bit long_hold_done = 1'b0;
	bit rx_took = 1'b0;

	// Parser state as predicted from the accepted characters.
	parse_phase_t phase_now;
	logic [31:0]  active_sync;
	logic [23:0]  tail_chars;
	logic [2:0]   char_count;
	logic [13:0]  length_val;
	logic         length_done;
	logic [13:0]  payload_idx;
	logic [6:0]   dec_val[3];
	logic         dec_done[3];
	logic [63:0]  addr_chars;
	logic [7:0]   code_char;
	logic [47:0]  reading_chars;

	always #5 clk = ~clk;

	ascii_sensor_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.sync_word(sync_word),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.network_id(network_id),
		.node_address(node_address),
		.sensor_code(sensor_code),
		.sensor_reading(sensor_reading),
		.time_stamp(time_stamp),
		.link_quality(link_quality),
		.frame_length(frame_length),
		.short_frame(short_frame)
	);

	function automatic bit is_dec_char(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Decimal fields convert like atoi: the first non-digit freezes the value.
	function automatic void feed_decimal(input int k, input logic [7:0] c);
		if (!dec_done[k]) begin
			if (is_dec_char(c))
				dec_val[k] = 7'(dec_val[k] * 10 + (c - 8'h30));
			else
				dec_done[k] = 1'b1;
		end
	endfunction

	function automatic void clear_frame();
		for (int k = 0; k < 3; k++) begin
			dec_val[k] = '0;
			dec_done[k] = 1'b0;
		end
		addr_chars = '0;
		code_char = '0;
		reading_chars = '0;
		payload_idx = '0;
	endfunction

	function automatic void restart_hunt();
		phase_now = PH_HUNT;
		tail_chars = '0;
		char_count = '0;
	endfunction

	function automatic void emit_record();
		asfp_pkg::record_t rec;
		rec.network_id = dec_val[0];
		rec.node_address = addr_chars;
		rec.sensor_code = code_char;
		rec.sensor_reading = reading_chars;
		rec.time_stamp = dec_val[1];
		rec.link_quality = dec_val[2];
		rec.frame_length = length_val;
		rec.short_frame = (length_val < FULL_LEN);
		pending_records.push_back(rec);
	endfunction

	// Advance the predicted parser by one accepted character.
	task automatic parse_char(input logic [7:0] c);
		logic [31:0] window;
		int idx;
		case (phase_now)
		PH_LENGTH: begin
			if (!length_done && is_dec_char(c))
				length_val = 14'(length_val * 10 + (c - 8'h30));
			else
				length_done = 1'b1;
			char_count = char_count + 3'd1;
			if (char_count >= DIGITS) begin
				if (length_val == 0) begin
					emit_record();
					restart_hunt();
				end else begin
					phase_now = PH_PAYLOAD;
					payload_idx = '0;
				end
			end
		end
		PH_PAYLOAD: begin
			idx = int'(payload_idx);
			if (idx < NET_END)
				feed_decimal(0, c);
			else if (idx < ADDR_END)
				addr_chars[8 * (ADDR_END - 1 - idx) +: 8] = c;
			else if (idx == CODE_AT)
				code_char = c;
			else if (idx < READ_END)
				reading_chars[8 * (READ_END - 1 - idx) +: 8] = c;
			else if (idx < STAMP_END)
				feed_decimal(1, c);
			else if (idx < LINK_END)
				feed_decimal(2, c);
			payload_idx = payload_idx + 14'd1;
			if (payload_idx >= length_val) begin
				emit_record();
				restart_hunt();
			end
		end
		default: begin
			// The window only counts once four characters arrived since the hunt began.
			window = {tail_chars, c};
			if (char_count >= 3 && window == active_sync) begin
				phase_now = PH_LENGTH;
				char_count = '0;
				tail_chars = '0;
				length_val = '0;
				length_done = 1'b0;
				clear_frame();
			end else begin
				tail_chars = window[23:0];
				if (char_count < 3)
					char_count = char_count + 3'd1;
			end
		end
		endcase
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Sample every request at the rising edge: predict, check, and watch for a hang.
	always @(posedge clk) begin
		bit moved;
		asfp_pkg::record_t want;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				active_sync = sync_word;
				moved = 1'b1;
			end
			if (rx_valid && rx_ready) begin
				parse_char(rx_byte);
				rx_took = 1'b1;
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (pending_records.size() == 0) begin
					$display("%0t: record expected none, got network_id %0d frame_length %0d",
						$time, network_id, frame_length);
					mismatches++;
				end else begin
					want = pending_records.pop_front();
					check_field("network_id", 64'(want.network_id), 64'(network_id));
					check_field("node_address", want.node_address, node_address);
					check_field("sensor_code", 64'(want.sensor_code), 64'(sensor_code));
					check_field("sensor_reading", 64'(want.sensor_reading),
						64'(sensor_reading));
					check_field("time_stamp", 64'(want.time_stamp), 64'(time_stamp));
					check_field("link_quality", 64'(want.link_quality), 64'(link_quality));
					check_field("frame_length", 64'(want.frame_length), 64'(frame_length));
					check_field("short_frame", 64'(want.short_frame), 64'(short_frame));
				end
			end
			if (moved)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: timeout, no request accepted for %0d cycles", $time, STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Character driver: holds each request until it is taken, with random gap bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (rx_valid && !rx_took) begin
			rx_valid <= 1'b1;
		end else if (rx_gap_left > 0) begin
			rx_gap_left--;
			rx_valid <= 1'b0;
		end else if (stream_chars.size() != 0 && rx_gap_pct != 0 &&
				$urandom_range(0, 99) < rx_gap_pct) begin
			rx_gap_left = $urandom_range(0, 9);
			rx_valid <= 1'b0;
		end else if (stream_chars.size() != 0) begin
			rx_valid <= 1'b1;
			rx_byte <= stream_chars.pop_front();
		end else begin
			rx_valid <= 1'b0;
		end
		rx_took = 1'b0;
	end

	// Record receiver: random stall bursts and one long hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (long_hold_go && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
			hold_left = $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic void push_char(input logic [7:0] c);
		stream_chars.push_back(c);
		queued_chars++;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endfunction

	function automatic void push_word(input logic [31:0] w);
		for (int i = 3; i >= 0; i--)
			push_char(w[8 * i +: 8]);
	endfunction

	// Half digits, half any byte: keeps the decimal conversions busy.
	function automatic logic [7:0] rand_char();
		if ($urandom_range(0, 1) != 0)
			return 8'(8'h30 + $urandom_range(0, 9));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] rand_non_digit();
		logic [7:0] c;
		c = 8'($urandom_range(0, 245));
		if (c >= 8'h30)
			c = c + 8'd10;
		return c;
	endfunction

	// A whole frame: sync, zero-padded length digits, payload. Tidy frames carry digits
	// in the decimal fields and raw bytes elsewhere.
	function automatic void push_frame(input logic [31:0] w, input int len, input bit tidy);
		push_word(w);
		push_text($sformatf("%04d", len));
		for (int i = 0; i < len; i++) begin
			if (tidy && (i < NET_END || (i >= READ_END && i < LINK_END)))
				push_char(8'(8'h30 + $urandom_range(0, 9)));
			else if (tidy)
				push_char(8'($urandom_range(0, 255)));
			else
				push_char(rand_char());
		end
	endfunction

	// Wait until every character is taken and every record is out, then let the pipe empty.
	task automatic settle();
		while (stream_chars.size() != 0 || rx_valid || pending_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_sync(input logic [31:0] w);
		@(negedge clk);
		cfg_valid <= 1'b1;
		sync_word <= w;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed frames with random content; the rest noise and broken frames.
	function automatic void random_stream(input logic [31:0] w, input int n_chars);
		int target;
		int r;
		int len;
		target = queued_chars + n_chars;
		while (queued_chars < target) begin
			r = $urandom_range(0, 99);
			if (r < 78) begin
				len = $urandom_range(0, 99);
				if (len < 60)
					len = $urandom_range(0, 30);
				else if (len < 95)
					len = $urandom_range(31, 60);
				else
					len = $urandom_range(100, 300);
				push_frame(w, len, $urandom_range(0, 4) != 0);
			end else if (r < 88) begin
				repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
			end else if (r < 94) begin
				// Length field cut short by a non-digit.
				push_word(w);
				push_char(8'(8'h30 + $urandom_range(0, 9)));
				push_char(rand_non_digit());
				push_char(rand_char());
				push_char(rand_char());
			end else begin
				// Only the start of the sync marker, then something else.
				len = $urandom_range(1, 3);
				for (int i = 3; i > 3 - len; i--)
					push_char(w[8 * i +: 8]);
				push_char(rand_char());
			end
		end
	endfunction

	initial begin
		restart_hunt();
		clear_frame();
		active_sync = asfp_pkg::SYNC_WORD_RESET;
		length_val = '0;
		length_done = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames on the reset sync word, with light idling on both sides.
		rx_gap_pct = 15;
		out_stall_pct = 15;
		push_text("51200021");
		push_text("42ADDR0001T+23.5C1788");
		// Partial match that slides one character, then a zero length.
		push_text("551200000");
		// Length digits that stop early or never start.
		push_text("5120x123");
		push_text("5120+021");
		push_text("512012a4");
		push_text("7x");
		push_char(8'h00); push_char(8'hFF); push_char(8'h80); push_char(8'h7F);
		push_char(8'h01); push_char(8'hFE); push_char(8'h55); push_char(8'hAA);
		push_char(8'hFF);
		push_text("9");
		// Extra payload past the link quality, with broken decimal fields.
		push_text("5120003099");
		repeat (15) push_char(8'($urandom_range(0, 255)));
		push_text("x5+9");
		repeat (9) push_char(rand_char());
		push_text("512000015");
		// A frame ending in a sync prefix: the window must start empty again.
		push_text("51200003512");
		push_text("00005");
		push_frame(asfp_pkg::SYNC_WORD_RESET, 20, 1'b1);
		push_frame(asfp_pkg::SYNC_WORD_RESET, 21, 1'b1);
		push_frame(asfp_pkg::SYNC_WORD_RESET, 120, 1'b0);
		settle();

		// All-zero sync word: zero characters in the stream can match it.
		write_sync(32'h0000_0000);
		push_char(8'h00); push_char(8'h00); push_char(8'h00);
		push_char(8'h00); push_char(8'h00);
		push_text("0025");
		push_frame(32'h0000_0000, 25, 1'b1);
		push_frame(32'h0000_0000, 0, 1'b1);
		settle();

		// All-ones sync word.
		write_sync(32'hFFFF_FFFF);
		push_frame(32'hFFFF_FFFF, 21, 1'b0);
		push_char(8'hFF); push_char(8'hFF);
		push_frame(32'hFFFF_FFFF, 7, 1'b1);
		settle();

		// Random streams: sync of printable digits, heavy idling on both sides.
		rx_gap_pct = 20;
		out_stall_pct = 20;
		write_sync({8'(8'h30 + $urandom_range(0, 9)), 8'(8'h30 + $urandom_range(0, 9)),
			8'(8'h30 + $urandom_range(0, 9)), 8'(8'h30 + $urandom_range(0, 9))});
		random_stream(active_sync, RANDOM_CHARS / 4);
		settle();

		// Any sync word; only the receiver stalls.
		rx_gap_pct = 0;
		out_stall_pct = 30;
		write_sync($urandom());
		random_stream(active_sync, RANDOM_CHARS / 4);
		settle();

		// Back to the reset word; a long receiver hold-off fills the block.
		out_stall_pct = 0;
		write_sync(asfp_pkg::SYNC_WORD_RESET);
		long_hold_go = 1'b1;
		random_stream(active_sync, RANDOM_CHARS / 4);
		settle();

		// Final stretch with no idling at all.
		write_sync($urandom());
		random_stream(active_sync, RANDOM_CHARS / 4);
		settle();

		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
